>>> hw/rtl/assert_macros.svh
// ============================================================================
// assert_macros.svh: shared assertion macros for the glyph blitter RTL
// Every assertion is clocked on clk_i and is off while rst_ni is low.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge once out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The condition must never be true at a clock edge once out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

>>> hw/rtl/cgb_pkg.sv
// ============================================================================
// cgb_pkg: glyph blitter shared types and constants
// Register indexes, reset values, and the control and status structs that
// pass between the controller and the datapath.
// ============================================================================
`timescale 1ns / 1ps

package cgb_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_FG_COLOR   = 3'd0;
  localparam logic [2:0] REG_BG_COLOR   = 3'd1;
  localparam logic [2:0] REG_SCALE      = 3'd2;
  localparam logic [2:0] REG_COL_OFFSET = 3'd3;
  localparam logic [2:0] REG_ROW_OFFSET = 3'd4;

  // Reset values
  localparam logic [15:0] FG_COLOR_RST   = 16'hFFFF;
  localparam logic [15:0] BG_COLOR_RST   = 16'h0000;
  localparam logic [1:0]  SCALE_RST      = 2'd1;
  localparam logic [6:0]  COL_OFFSET_RST = 7'd2;
  localparam logic [6:0]  ROW_OFFSET_RST = 7'd3;

  // Pixels packed into one output word
  localparam int unsigned GROUP_PIXELS = 4;

  typedef struct packed {
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [1:0]  scale;
    logic [6:0]  col_offset;
    logic [6:0]  row_offset;
  } cgb_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture an input word
    logic setup;    // clip the glyph, advance the cursor
    logic advance;  // step past the group just taken
  } cgb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic visible;  // clipped window is not empty (valid in setup)
    logic last;     // current group holds the final pixel
  } cgb_sts_t;

endpackage

>>> hw/rtl/cgb_ctrl.sv
// ============================================================================
// cgb_ctrl: glyph blitter controller
// Sequences load, clip setup and group emission for one glyph at a time.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cgb_ctrl
  import cgb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  cgb_sts_t sts_i,
  output cgb_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = sts_i.visible ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_NEVER(a_ready_while_emit, in_ready_o && out_valid_o,
                "input taken while a glyph is still being emitted")
  `ASSERT_CLK(a_clipped_goes_idle,
              (state_q == ST_SETUP && !sts_i.visible) |=> (state_q == ST_IDLE),
              "fully clipped glyph did not return to idle")
  `ASSERT_CLK(a_last_ends_glyph,
              (out_valid_o && out_ready_i && sts_i.last) |=> in_ready_o,
              "last word taken but controller not idle")
  `ASSERT_CLK(a_load_then_setup, cmd_o.load |=> cmd_o.setup,
              "captured word not followed by setup")

endmodule

>>> hw/rtl/cgb_dp.sv
// ============================================================================
// cgb_dp: glyph blitter datapath
// Cursor, clip computation and the four-pixel group walker.
// ============================================================================
`timescale 1ns / 1ps

module cgb_dp
  import cgb_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cgb_cmd_t    cmd_i,
  output cgb_sts_t    sts_o,
  input  cgb_cfg_t    cfg_i,
  input  logic        start_of_string_i,
  input  logic [15:0] start_x_i,
  input  logic [15:0] text_y_i,
  input  logic [63:0] glyph_rows_i,
  output logic [7:0]  window_x_start_o,
  output logic [7:0]  window_y_start_o,
  output logic [7:0]  window_x_end_o,
  output logic [7:0]  window_y_end_o,
  output logic [15:0] pixel_a_o,
  output logic [15:0] pixel_b_o,
  output logic [15:0] pixel_c_o,
  output logic [15:0] pixel_d_o,
  output logic [2:0]  valid_pixels_o,
  output logic        first_of_glyph_o,
  output logic        last_of_glyph_o
);

  localparam logic signed [17:0] XLim = 18'(SCREEN_WIDTH - 1);
  localparam logic signed [17:0] YLim = 18'(SCREEN_HEIGHT - 1);

  logic        scale2;
  logic [15:0] cursor_q;
  logic        first_q;
  logic [15:0] cx_q, ty_q;
  logic [63:0] glyph_q;
  logic [7:0]  wxs_q, wys_q, wxe_q, wye_q;
  logic [3:0]  cbase_q, rbase_q, wm1_q, hm1_q;
  logic [3:0]  r_q, c_q;

  // Clip setup
  logic signed [17:0] cx_s, ty_s, cxe_s, tye_s, size_m1;
  logic signed [17:0] x0_s, x1_s, y0_s, y1_s;
  logic               vis_x, vis_y;

  assign scale2  = cfg_i.scale[1];
  assign size_m1 = scale2 ? 18'sd15 : 18'sd7;

  always_comb begin
    cx_s  = {{2{cx_q[15]}}, cx_q};
    ty_s  = {{2{ty_q[15]}}, ty_q};
    cxe_s = cx_s + size_m1;
    tye_s = ty_s + size_m1;
    x0_s  = cx_s[17] ? '0 : cx_s;
    y0_s  = ty_s[17] ? '0 : ty_s;
    x1_s  = (cxe_s > XLim) ? XLim : cxe_s;
    y1_s  = (tye_s > YLim) ? YLim : tye_s;
    vis_x = (cx_s <= XLim) && !cxe_s[17];
    vis_y = (ty_s <= YLim) && !tye_s[17];
  end

  assign sts_o.visible = vis_x && vis_y;

  // Group walker: up to four row-major steps over the window
  logic [3:0]  rr, cc, gr, gc;
  logic [2:0]  ridx, cidx;
  logic        alive, any_last, lastk;
  logic [2:0]  cnt;
  logic [15:0] pix [GROUP_PIXELS];

  always_comb begin
    rr       = r_q;
    cc       = c_q;
    alive    = 1'b1;
    any_last = 1'b0;
    cnt      = '0;
    gr       = '0;
    gc       = '0;
    ridx     = '0;
    cidx     = '0;
    lastk    = 1'b0;
    for (int k = 0; k < GROUP_PIXELS; k++) begin
      gr     = rbase_q + rr;
      gc     = cbase_q + cc;
      ridx   = scale2 ? gr[3:1] : gr[2:0];
      cidx   = scale2 ? gc[3:1] : gc[2:0];
      pix[k] = '0;
      if (alive) begin
        pix[k] = glyph_q[{ridx, ~cidx}] ? cfg_i.fg_color : cfg_i.bg_color;
        cnt    = cnt + 3'd1;
      end
      lastk = (rr == hm1_q) && (cc == wm1_q);
      if (alive && lastk) begin
        any_last = 1'b1;
        alive    = 1'b0;
      end
      if (cc == wm1_q) begin
        cc = '0;
        rr = rr + 4'd1;
      end else begin
        cc = cc + 4'd1;
      end
    end
  end

  assign sts_o.last = any_last;

  assign window_x_start_o = wxs_q;
  assign window_y_start_o = wys_q;
  assign window_x_end_o   = wxe_q;
  assign window_y_end_o   = wye_q;
  assign pixel_a_o        = pix[0];
  assign pixel_b_o        = pix[1];
  assign pixel_c_o        = pix[2];
  assign pixel_d_o        = pix[3];
  assign valid_pixels_o   = cnt;
  assign first_of_glyph_o = first_q;
  assign last_of_glyph_o  = any_last;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      first_q  <= 1'b0;
    end else begin
      if (cmd_i.setup) begin
        cursor_q <= cx_q + (scale2 ? 16'd16 : 16'd8);
        first_q  <= 1'b1;
      end else if (cmd_i.advance) begin
        first_q  <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q    <= start_of_string_i ? start_x_i : cursor_q;
      ty_q    <= text_y_i;
      glyph_q <= glyph_rows_i;
    end
    if (cmd_i.setup) begin
      wxs_q   <= x0_s[7:0] + {1'b0, cfg_i.col_offset};
      wxe_q   <= x1_s[7:0] + {1'b0, cfg_i.col_offset};
      wys_q   <= y0_s[7:0] + {1'b0, cfg_i.row_offset};
      wye_q   <= y1_s[7:0] + {1'b0, cfg_i.row_offset};
      cbase_q <= cx_q[15] ? 4'(-cx_q) : 4'd0;
      rbase_q <= ty_q[15] ? 4'(-ty_q) : 4'd0;
      wm1_q   <= 4'(x1_s - x0_s);
      hm1_q   <= 4'(y1_s - y0_s);
      r_q     <= '0;
      c_q     <= '0;
    end else if (cmd_i.advance) begin
      r_q <= rr;
      c_q <= cc;
    end
  end

endmodule

>>> hw/rtl/clipped_bitmap_glyph_blitter_core.sv
// ============================================================================
// clipped_bitmap_glyph_blitter_core: clipped 8x8 font glyph blitter
// Draws one glyph per input word at the text cursor, clipped to the screen.
// ============================================================================
// One input word carries an 8x8 glyph (row k in bits 8k+7..8k, bit 7 is the
// leftmost pixel), a start-of-string flag with its start x, and the top row.
// The glyph is drawn at the cursor, magnified 1x or 2x, and clipped to a
// SCREEN_WIDTH x SCREEN_HEIGHT screen. Each output word carries the clipped
// window (panel offsets added, wrapping mod 256) and up to four RGB565 pixels
// in row-major order; pixels past valid_pixels read zero. A glyph clipped away
// entirely gives no output words, but the cursor still advances by 8 or 16.
// The word is taken, then the clip is set up, then the group walker steps up to
// four pixels a cycle through the window, giving one output word per cycle
// while out_ready_i is high. A new word is taken only once the previous glyph
// is fully delivered. Configuration writes are always accepted and should be
// issued while the block is idle.
`timescale 1ns / 1ps

module clipped_bitmap_glyph_blitter_core
  import cgb_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Glyph input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_of_string_i,
  input  logic [15:0] start_x_i,
  input  logic [15:0] text_y_i,
  input  logic [63:0] glyph_rows_i,
  // Pixel group output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  window_x_start_o,
  output logic [7:0]  window_y_start_o,
  output logic [7:0]  window_x_end_o,
  output logic [7:0]  window_y_end_o,
  output logic [15:0] pixel_a_o,
  output logic [15:0] pixel_b_o,
  output logic [15:0] pixel_c_o,
  output logic [15:0] pixel_d_o,
  output logic [2:0]  valid_pixels_o,
  output logic        first_of_glyph_o,
  output logic        last_of_glyph_o
);

  cgb_cfg_t cfg_q;
  cgb_cmd_t cmd;
  cgb_sts_t sts;
  logic     cfg_wr;

  // Register file: always ready, unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fg_color   <= FG_COLOR_RST;
      cfg_q.bg_color   <= BG_COLOR_RST;
      cfg_q.scale      <= SCALE_RST;
      cfg_q.col_offset <= COL_OFFSET_RST;
      cfg_q.row_offset <= ROW_OFFSET_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        REG_FG_COLOR:   cfg_q.fg_color   <= cfg_data_i;
        REG_BG_COLOR:   cfg_q.bg_color   <= cfg_data_i;
        REG_SCALE:      cfg_q.scale      <= cfg_data_i[1:0];
        REG_COL_OFFSET: cfg_q.col_offset <= cfg_data_i[6:0];
        REG_ROW_OFFSET: cfg_q.row_offset <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer: idle -> setup -> emit groups -> idle, or setup -> idle when fully clipped
  cgb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Cursor, clipping and pixel group walker
  cgb_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_i             (cfg_q),
    .start_of_string_i (start_of_string_i),
    .start_x_i         (start_x_i),
    .text_y_i          (text_y_i),
    .glyph_rows_i      (glyph_rows_i),
    .window_x_start_o  (window_x_start_o),
    .window_y_start_o  (window_y_start_o),
    .window_x_end_o    (window_x_end_o),
    .window_y_end_o    (window_y_end_o),
    .pixel_a_o         (pixel_a_o),
    .pixel_b_o         (pixel_b_o),
    .pixel_c_o         (pixel_c_o),
    .pixel_d_o         (pixel_d_o),
    .valid_pixels_o    (valid_pixels_o),
    .first_of_glyph_o  (first_of_glyph_o),
    .last_of_glyph_o   (last_of_glyph_o)
  );

endmodule
